/* hdl/evr_pkg.sv */
// Shared constants, types and the arctangent table for the Euler XYZ rotator.
package evr_pkg;

  // Port widths
  localparam int COORD_WIDTH = 32;
  localparam int ANGLE_WIDTH = 16;

  // Trig generation: 32-bit phase (full turn = 2^32), Q1.30 sine and cosine
  localparam int PHASE_WIDTH  = 32;
  localparam int TRIG_FRAC    = 30;
  localparam int TRIG_WIDTH   = TRIG_FRAC + 2;
  localparam int CORDIC_W     = TRIG_FRAC + 3;
  localparam int CORDIC_STEPS = 30;
  localparam int STEP_WIDTH   = $clog2(CORDIC_STEPS);

  // Rotation datapath: headroom for the point growing between axes
  localparam int IW         = COORD_WIDTH + 4;
  localparam int LO_WIDTH   = 32;
  localparam int HI_WIDTH   = IW - LO_WIDTH;
  localparam int MAG_T_W    = TRIG_WIDTH - 1;
  localparam int PL_W       = LO_WIDTH + MAG_T_W;
  localparam int PH_W       = HI_WIDTH + MAG_T_W;
  localparam int PW         = IW + 2;

  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = CORDIC_W'(64'sd652032874);
  localparam logic signed [CORDIC_W-1:0] TRIG_POS    = CORDIC_W'(64'sd1 <<< TRIG_FRAC);
  localparam logic signed [CORDIC_W-1:0] TRIG_NEG    = -TRIG_POS;
  localparam logic [PL_W:0]              ROUND_HALF  = (PL_W + 1)'(64'd1 << (TRIG_FRAC - 1));

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_t;

  // One CORDIC lane
  typedef struct packed {
    logic signed [CORDIC_W-1:0] x;
    logic signed [CORDIC_W-1:0] y;
    logic signed [CORDIC_W-1:0] z;
  } cord_t;

  // Beat moving down the CORDIC chain: three lanes plus the point
  typedef struct packed {
    logic                          valid;
    logic [2:0]                    flip;
    logic [2:0]                    on;
    cord_t [2:0]                   lane;
    logic signed [COORD_WIDTH-1:0] px;
    logic signed [COORD_WIDTH-1:0] py;
    logic signed [COORD_WIDTH-1:0] pz;
  } cstage_t;

  typedef struct packed {
    logic                         on;
    logic signed [TRIG_WIDTH-1:0] s;
    logic signed [TRIG_WIDTH-1:0] c;
  } trig_t;

  // Beat moving down the rotation stages
  typedef struct packed {
    logic                 valid;
    trig_t [2:0]          trig;
    logic signed [IW-1:0] x;
    logic signed [IW-1:0] y;
    logic signed [IW-1:0] z;
  } pt_t;

  // Rounded atan(2^-i) as a fraction of a full turn times 2^32
  function automatic logic [PHASE_WIDTH-1:0] atan_phase(input logic [STEP_WIDTH-1:0] i);
    logic [PHASE_WIDTH-1:0] r;
    case (i)
      5'd0:  r = 32'd536870912;
      5'd1:  r = 32'd316933406;
      5'd2:  r = 32'd167458907;
      5'd3:  r = 32'd85004756;
      5'd4:  r = 32'd42667331;
      5'd5:  r = 32'd21354465;
      5'd6:  r = 32'd10679838;
      5'd7:  r = 32'd5340245;
      5'd8:  r = 32'd2670163;
      5'd9:  r = 32'd1335087;
      5'd10: r = 32'd667544;
      5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;
      5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;
      5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;
      5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;
      5'd19: r = 32'd1304;
      5'd20: r = 32'd652;
      5'd21: r = 32'd326;
      5'd22: r = 32'd163;
      5'd23: r = 32'd81;
      5'd24: r = 32'd41;
      5'd25: r = 32'd20;
      5'd26: r = 32'd10;
      5'd27: r = 32'd5;
      5'd28: r = 32'd3;
      5'd29: r = 32'd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

/* hdl/evr_ifs.sv */
// Valid/ready channel interfaces for the point input and the rotated result.
interface evr_in_if import evr_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] coord_x;
  logic signed [COORD_WIDTH-1:0] coord_y;
  logic signed [COORD_WIDTH-1:0] coord_z;
  logic signed [ANGLE_WIDTH-1:0] angle_about_x;
  logic signed [ANGLE_WIDTH-1:0] angle_about_y;
  logic signed [ANGLE_WIDTH-1:0] angle_about_z;

  modport source (output valid, coord_x, coord_y, coord_z,
                  angle_about_x, angle_about_y, angle_about_z, input ready);
  modport sink   (input valid, coord_x, coord_y, coord_z,
                  angle_about_x, angle_about_y, angle_about_z, output ready);
endinterface

interface evr_out_if import evr_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] rotated_x;
  logic signed [COORD_WIDTH-1:0] rotated_y;
  logic signed [COORD_WIDTH-1:0] rotated_z;
  logic                          saturated;

  modport source (output valid, rotated_x, rotated_y, rotated_z, saturated, input ready);
  modport sink   (input valid, rotated_x, rotated_y, rotated_z, saturated, output ready);
endinterface

/* hdl/evr_cordic_cell.sv */
// One CORDIC micro-rotation for all three angle lanes, registered.
module evr_cordic_cell import evr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic [STEP_WIDTH-1:0] step,
  input  cstage_t               d,
  output cstage_t               q
);

  cstage_t q_r;
  cstage_t q_nxt;

  // Turn each lane toward zero residual phase
  always_comb begin
    logic signed [CORDIC_W-1:0] x_sh;
    logic signed [CORDIC_W-1:0] y_sh;
    logic signed [CORDIC_W-1:0] ang;
    q_nxt = d;
    ang   = $signed({{(CORDIC_W - PHASE_WIDTH){1'b0}}, atan_phase(step)});
    for (int k = 0; k < 3; k++) begin
      x_sh = d.lane[k].x >>> step;
      y_sh = d.lane[k].y >>> step;
      if (d.lane[k].z >= 0) begin
        q_nxt.lane[k].x = d.lane[k].x - y_sh;
        q_nxt.lane[k].y = d.lane[k].y + x_sh;
        q_nxt.lane[k].z = d.lane[k].z - ang;
      end else begin
        q_nxt.lane[k].x = d.lane[k].x + y_sh;
        q_nxt.lane[k].y = d.lane[k].y - x_sh;
        q_nxt.lane[k].z = d.lane[k].z + ang;
      end
    end
  end

  // Advance the beat when the pipe moves
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.valid <= 1'b0;
    end else if (en) begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

/* hdl/evr_rot_unit.sv */
// Rotation of the point about one axis: multiply, round, then add, in three stages.
module evr_rot_unit import evr_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  axis_t axis,
  input  pt_t   d,
  output pt_t   q
);

  pt_t              s1_r;
  pt_t              s2_r;
  pt_t              q_r;
  pt_t              q_nxt;
  logic [PL_W-1:0]  pl_r  [4];
  logic [PL_W-1:0]  pl_nxt[4];
  logic [PH_W-1:0]  ph_r  [4];
  logic [PH_W-1:0]  ph_nxt[4];
  logic [3:0]       neg_r;
  logic [3:0]       neg_nxt;
  logic signed [PW-1:0] p_r  [4];
  logic signed [PW-1:0] p_nxt[4];

  // Pick the coordinate pair and trig for this axis, take magnitudes, multiply
  always_comb begin
    logic signed [IW-1:0]         u;
    logic signed [IW-1:0]         w;
    trig_t                        t;
    logic signed [IW-1:0]         a [4];
    logic signed [TRIG_WIDTH-1:0] tv[4];
    logic [IW-1:0]                ua;
    logic [MAG_T_W-1:0]           ut;
    case (axis)
      AXIS_X: begin u = d.y; w = d.z; t = d.trig[0]; end
      AXIS_Y: begin u = d.z; w = d.x; t = d.trig[1]; end
      AXIS_Z: begin u = d.x; w = d.y; t = d.trig[2]; end
      default: begin u = d.x; w = d.y; t = d.trig[2]; end
    endcase
    a[0] = u; tv[0] = t.c;
    a[1] = w; tv[1] = t.s;
    a[2] = u; tv[2] = t.s;
    a[3] = w; tv[3] = t.c;
    for (int k = 0; k < 4; k++) begin
      ua = a[k][IW-1] ? IW'(-a[k]) : IW'(a[k]);
      ut = tv[k][TRIG_WIDTH-1] ? MAG_T_W'(-tv[k]) : MAG_T_W'(tv[k]);
      neg_nxt[k] = a[k][IW-1] ^ tv[k][TRIG_WIDTH-1];
      pl_nxt[k]  = PL_W'(ua[LO_WIDTH-1:0]) * PL_W'(ut);
      ph_nxt[k]  = PH_W'(ua[IW-1:LO_WIDTH]) * PH_W'(ut);
    end
  end

  // Scale by 2^-30, round half away from zero, restore sign
  always_comb begin
    logic [PL_W:0]   rnd;
    logic [PW-1:0]   mag;
    for (int k = 0; k < 4; k++) begin
      rnd      = {1'b0, pl_r[k]} + ROUND_HALF;
      mag      = (PW'(ph_r[k]) << (LO_WIDTH - TRIG_FRAC)) + PW'(rnd >> TRIG_FRAC);
      p_nxt[k] = neg_r[k] ? -$signed(mag) : $signed(mag);
    end
  end

  // Combine products and write the pair back; skip axes with a zero angle
  always_comb begin
    logic signed [IW-1:0] nu;
    logic signed [IW-1:0] nw;
    q_nxt = s2_r;
    nu    = IW'(p_r[0] - p_r[1]);
    nw    = IW'(p_r[2] + p_r[3]);
    case (axis)
      AXIS_X: if (s2_r.trig[0].on) begin q_nxt.y = nu; q_nxt.z = nw; end
      AXIS_Y: if (s2_r.trig[1].on) begin q_nxt.z = nu; q_nxt.x = nw; end
      AXIS_Z: if (s2_r.trig[2].on) begin q_nxt.x = nu; q_nxt.y = nw; end
      default: q_nxt = s2_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.valid <= 1'b0;
      s2_r.valid <= 1'b0;
      q_r.valid  <= 1'b0;
    end else if (en) begin
      s1_r  <= d;
      pl_r  <= pl_nxt;
      ph_r  <= ph_nxt;
      neg_r <= neg_nxt;
      s2_r  <= s1_r;
      p_r   <= p_nxt;
      q_r   <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

/* hdl/euler_xyz_vector_rotate.sv */
// Top level: Euler XYZ rotation of a Q16.16 point with CORDIC trig and saturation.
//
// A point and three binary angles enter on in_chan; the point is rotated about x,
// then y, then z (an axis whose angle is zero is passed through untouched) and the
// result leaves on out_chan, clipped to 32 bits with saturated flagging any clip.
// One beat is accepted every cycle while the pipe is not held; from input to output
// the phases are set up on the way in without a register, then come 30 CORDIC cells that
// run the three angles side by side, one to fold and clamp sine and cosine, three
// stages per axis rotation, and the output register. The whole pipe holds while a
// result sits unclaimed in the output register, so input is refused only then.
module euler_xyz_vector_rotate import evr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  evr_in_if.sink    in_chan,
  evr_out_if.source out_chan
);

  logic    en;
  cstage_t chain [CORDIC_STEPS+1];
  pt_t     trig_r;
  pt_t     trig_nxt;
  pt_t     rot [4];

  logic                          out_valid_r;
  logic signed [COORD_WIDTH-1:0] out_x_r;
  logic signed [COORD_WIDTH-1:0] out_y_r;
  logic signed [COORD_WIDTH-1:0] out_z_r;
  logic                          out_sat_r;
  logic signed [COORD_WIDTH-1:0] sat_v  [3];
  logic                          sat_nxt;

  // Move everything while the output register is free or being taken
  assign en            = !out_valid_r || out_chan.ready;
  assign in_chan.ready = en;

  // Place each angle in a 32-bit phase, fold quadrants two and three by pi
  always_comb begin
    logic [ANGLE_WIDTH-1:0] ang [3];
    logic [PHASE_WIDTH-1:0] ph;
    logic                   fl;
    ang[0] = in_chan.angle_about_x;
    ang[1] = in_chan.angle_about_y;
    ang[2] = in_chan.angle_about_z;
    chain[0].valid = in_chan.valid;
    chain[0].px    = in_chan.coord_x;
    chain[0].py    = in_chan.coord_y;
    chain[0].pz    = in_chan.coord_z;
    for (int k = 0; k < 3; k++) begin
      ph = {ang[k], {(PHASE_WIDTH - ANGLE_WIDTH){1'b0}}};
      fl = ph[PHASE_WIDTH-1] ^ ph[PHASE_WIDTH-2];
      ph[PHASE_WIDTH-1] = ph[PHASE_WIDTH-1] ^ fl;
      chain[0].flip[k]   = fl;
      chain[0].on[k]     = |ang[k];
      chain[0].lane[k].x = CORDIC_GAIN;
      chain[0].lane[k].y = '0;
      chain[0].lane[k].z = CORDIC_W'($signed(ph));
    end
  end

  // Row of CORDIC cells, one micro-rotation each
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    evr_cordic_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .step  (STEP_WIDTH'(i)),
      .d     (chain[i]),
      .q     (chain[i+1])
    );
  end

  // Undo the fold, clamp to [-1, 1], widen the point
  always_comb begin
    logic signed [CORDIC_W-1:0] xc;
    logic signed [CORDIC_W-1:0] yc;
    trig_nxt.valid = chain[CORDIC_STEPS].valid;
    trig_nxt.x     = IW'(chain[CORDIC_STEPS].px);
    trig_nxt.y     = IW'(chain[CORDIC_STEPS].py);
    trig_nxt.z     = IW'(chain[CORDIC_STEPS].pz);
    for (int k = 0; k < 3; k++) begin
      xc = chain[CORDIC_STEPS].flip[k] ? -chain[CORDIC_STEPS].lane[k].x
                                        :  chain[CORDIC_STEPS].lane[k].x;
      yc = chain[CORDIC_STEPS].flip[k] ? -chain[CORDIC_STEPS].lane[k].y
                                        :  chain[CORDIC_STEPS].lane[k].y;
      if (xc > TRIG_POS) xc = TRIG_POS;
      if (xc < TRIG_NEG) xc = TRIG_NEG;
      if (yc > TRIG_POS) yc = TRIG_POS;
      if (yc < TRIG_NEG) yc = TRIG_NEG;
      trig_nxt.trig[k].on = chain[CORDIC_STEPS].on[k];
      trig_nxt.trig[k].c  = TRIG_WIDTH'(xc);
      trig_nxt.trig[k].s  = TRIG_WIDTH'(yc);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trig_r.valid <= 1'b0;
    end else if (en) begin
      trig_r <= trig_nxt;
    end
  end

  assign rot[0] = trig_r;

  evr_rot_unit u_rot_x (
    .clk (clk), .rst_n (rst_n), .en (en), .axis (AXIS_X), .d (rot[0]), .q (rot[1])
  );
  evr_rot_unit u_rot_y (
    .clk (clk), .rst_n (rst_n), .en (en), .axis (AXIS_Y), .d (rot[1]), .q (rot[2])
  );
  evr_rot_unit u_rot_z (
    .clk (clk), .rst_n (rst_n), .en (en), .axis (AXIS_Z), .d (rot[2]), .q (rot[3])
  );

  // Clip each component to the coordinate range
  always_comb begin
    logic signed [IW-1:0] v [3];
    logic signed [IW-1:0] hi;
    logic signed [IW-1:0] lo;
    hi      = IW'({1'b0, {(COORD_WIDTH - 1){1'b1}}});
    lo      = -hi - IW'(1);
    v[0]    = rot[3].x;
    v[1]    = rot[3].y;
    v[2]    = rot[3].z;
    sat_nxt = 1'b0;
    for (int k = 0; k < 3; k++) begin
      if (v[k] > hi) begin
        sat_v[k] = COORD_WIDTH'(hi);
        sat_nxt  = 1'b1;
      end else if (v[k] < lo) begin
        sat_v[k] = COORD_WIDTH'(lo);
        sat_nxt  = 1'b1;
      end else begin
        sat_v[k] = COORD_WIDTH'(v[k]);
      end
    end
  end

  // Output register: hold the beat until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= rot[3].valid;
      out_x_r     <= sat_v[0];
      out_y_r     <= sat_v[1];
      out_z_r     <= sat_v[2];
      out_sat_r   <= sat_nxt;
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.rotated_x = out_x_r;
  assign out_chan.rotated_y = out_y_r;
  assign out_chan.rotated_z = out_z_r;
  assign out_chan.saturated = out_sat_r;

endmodule

/* hdl/evr_check.sv */
// Port-level checks for the rotator, bound to the top level.
module evr_check import evr_pkg::*; (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [COORD_WIDTH-1:0] rx,
  input logic signed [COORD_WIDTH-1:0] ry,
  input logic signed [COORD_WIDTH-1:0] rz,
  input logic                          sat
);

  localparam logic signed [COORD_WIDTH-1:0] CMAX = {1'b0, {(COORD_WIDTH - 1){1'b1}}};
  localparam logic signed [COORD_WIDTH-1:0] CMIN = {1'b1, {(COORD_WIDTH - 1){1'b0}}};

  // A waiting result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // A waiting result keeps its value
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(rx) && $stable(ry) && $stable(rz) && $stable(sat))
    else $error("result changed while stalled");

  // Input is never refused while the output register is empty
  a_in_open: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input refused with empty output");

  // A clip leaves at least one component at a range limit
  a_sat_edge: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && sat |-> rx == CMAX || rx == CMIN || ry == CMAX || ry == CMIN ||
                         rz == CMAX || rz == CMIN)
    else $error("saturated flag without a clipped component");

  // Reset empties the output
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind euler_xyz_vector_rotate evr_check u_evr_check (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .rx        (out_chan.rotated_x),
  .ry        (out_chan.rotated_y),
  .rz        (out_chan.rotated_z),
  .sat       (out_chan.saturated)
);

/* tb/sv/euler_xyz_vector_rotate_tb.sv */
// Testbench for the Euler XYZ rotator: random and directed points against a bit-exact predictor.
module euler_xyz_vector_rotate_tb import evr_pkg::*; ();

  typedef struct {
    logic signed [COORD_WIDTH-1:0] x;
    logic signed [COORD_WIDTH-1:0] y;
    logic signed [COORD_WIDTH-1:0] z;
    logic signed [ANGLE_WIDTH-1:0] ax;
    logic signed [ANGLE_WIDTH-1:0] ay;
    logic signed [ANGLE_WIDTH-1:0] az;
  } point_t;

  typedef struct {
    logic signed [COORD_WIDTH-1:0] x;
    logic signed [COORD_WIDTH-1:0] y;
    logic signed [COORD_WIDTH-1:0] z;
    logic                          sat;
  } rotated_t;

  // Tracks expected rotated points and compares them with the output beats
  class rotate_scoreboard;
    rotated_t pending[$];
    int       mismatches;
    int       checked;
    int       sat_seen;
    longint   atan_turn[30];

    function new();
      atan_turn = '{536870912, 316933406, 167458907, 85004756, 42667331,
                    21354465, 10679838, 5340245, 2670163, 1335087,
                    667544, 333772, 166886, 83443, 41722,
                    20861, 10430, 5215, 2608, 1304,
                    652, 326, 163, 81, 41, 20, 10, 5, 3, 1};
      mismatches = 0;
      checked = 0;
      sat_seen = 0;
    endfunction

    // Sine and cosine in Q1.30 from a 30-step CORDIC
    function void sincos(logic [ANGLE_WIDTH-1:0] a, output longint s, output longint c);
      logic [31:0] phase;
      logic        flip;
      longint      cx, cy, cz, nx;
      phase = {a, 16'd0};
      flip = (phase[31:30] == 2'd1) || (phase[31:30] == 2'd2);
      if (flip) phase = phase + 32'h8000_0000;
      cz = longint'(signed'(phase));
      cx = 652032874;
      cy = 0;
      for (int i = 0; i < 30; i++) begin
        if (cz >= 0) begin
          nx = cx - (cy >>> i);
          cy = cy + (cx >>> i);
          cz = cz - atan_turn[i];
        end else begin
          nx = cx + (cy >>> i);
          cy = cy - (cx >>> i);
          cz = cz + atan_turn[i];
        end
        cx = nx;
      end
      if (flip) begin
        cx = -cx;
        cy = -cy;
      end
      if (cx > 64'sd1073741824) cx = 64'sd1073741824;
      if (cx < -64'sd1073741824) cx = -64'sd1073741824;
      if (cy > 64'sd1073741824) cy = 64'sd1073741824;
      if (cy < -64'sd1073741824) cy = -64'sd1073741824;
      s = cy;
      c = cx;
    endfunction

    // Exact product scaled by 2^-30, rounded half away from zero
    function longint scale(longint a, longint t);
      logic [127:0] ua, ut, p;
      logic         neg;
      neg = (a < 0) != (t < 0);
      ua = 128'(a < 0 ? -a : a);
      ut = 128'(t < 0 ? -t : t);
      p = (ua * ut + (128'd1 << 29)) >> 30;
      return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
    endfunction

    function logic signed [COORD_WIDTH-1:0] clip(longint v, inout logic sat);
      if (v > 64'sd2147483647) begin
        sat = 1'b1;
        return 32'sh7fff_ffff;
      end
      if (v < -64'sd2147483648) begin
        sat = 1'b1;
        return 32'sh8000_0000;
      end
      return v[31:0];
    endfunction

    // Predict the rotated point for an accepted input beat
    function void note_point(point_t p);
      longint   px, py, pz, s, c, v;
      rotated_t r;
      px = p.x;
      py = p.y;
      pz = p.z;
      if (p.ax != 0) begin
        sincos(p.ax, s, c);
        v = py;
        py = scale(v, c) - scale(pz, s);
        pz = scale(v, s) + scale(pz, c);
      end
      if (p.ay != 0) begin
        sincos(p.ay, s, c);
        v = px;
        px = scale(v, c) + scale(pz, s);
        pz = scale(pz, c) - scale(v, s);
      end
      if (p.az != 0) begin
        sincos(p.az, s, c);
        v = px;
        px = scale(v, c) - scale(py, s);
        py = scale(v, s) + scale(py, c);
      end
      r.sat = 1'b0;
      r.x = clip(px, r.sat);
      r.y = clip(py, r.sat);
      r.z = clip(pz, r.sat);
      pending.push_back(r);
    endfunction

    function void report(string what);
      mismatches++;
      $display("MISMATCH @%0t: %s", $time, what);
    endfunction

    function void check_result(rotated_t got);
      rotated_t want;
      if (pending.size() == 0) begin
        report("result beat with nothing expected");
        return;
      end
      want = pending.pop_front();
      checked++;
      if (want.sat) sat_seen++;
      if (got.x !== want.x)
        report($sformatf("rotated_x got %0d want %0d", got.x, want.x));
      if (got.y !== want.y)
        report($sformatf("rotated_y got %0d want %0d", got.y, want.y));
      if (got.z !== want.z)
        report($sformatf("rotated_z got %0d want %0d", got.z, want.z));
      if (got.sat !== want.sat)
        report($sformatf("saturated got %0b want %0b", got.sat, want.sat));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   cycles = 0;
  int   send_idle_pct = 32;
  int   recv_idle_pct = 52;
  rotate_scoreboard sb = new();

  evr_in_if  in_chan ();
  evr_out_if out_chan ();

  euler_xyz_vector_rotate u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan.sink),
    .out_chan(out_chan.source)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    in_chan.valid = 1'b0;
    in_chan.coord_x = '0;
    in_chan.coord_y = '0;
    in_chan.coord_z = '0;
    in_chan.angle_about_x = '0;
    in_chan.angle_about_y = '0;
    in_chan.angle_about_z = '0;
    out_chan.ready = 1'b0;
  end

  // Stall the result side at random
  always @(posedge clk) begin
    out_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Capture accepted beats on both channels
  always @(posedge clk) begin
    point_t   p;
    rotated_t r;
    if (rst_n && in_chan.valid && in_chan.ready) begin
      p.x = in_chan.coord_x;
      p.y = in_chan.coord_y;
      p.z = in_chan.coord_z;
      p.ax = in_chan.angle_about_x;
      p.ay = in_chan.angle_about_y;
      p.az = in_chan.angle_about_z;
      sb.note_point(p);
    end
    if (rst_n && out_chan.valid && out_chan.ready) begin
      r.x = out_chan.rotated_x;
      r.y = out_chan.rotated_y;
      r.z = out_chan.rotated_z;
      r.sat = out_chan.saturated;
      sb.check_result(r);
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > 200000) begin
      $display("timeout after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Present one point, idling first at random, and hold until accepted
  task automatic send_point(point_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.coord_x <= p.x;
    in_chan.coord_y <= p.y;
    in_chan.coord_z <= p.z;
    in_chan.angle_about_x <= p.ax;
    in_chan.angle_about_y <= p.ay;
    in_chan.angle_about_z <= p.az;
    do @(posedge clk); while (!in_chan.ready);
  endtask

  function automatic point_t make_point(longint x, longint y, longint z,
                                        int ax, int ay, int az);
    point_t p;
    p.x = x[31:0];
    p.y = y[31:0];
    p.z = z[31:0];
    p.ax = ax[15:0];
    p.ay = ay[15:0];
    p.az = az[15:0];
    return p;
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return $urandom();
      1: return 32'(int'($urandom_range(131072)) - 65536);
      2: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
      3: return 32'(int'($urandom_range(2000000)) - 1000000) << 8;
      default: return 32'(int'($urandom_range(200000000)) - 100000000);
    endcase
  endfunction

  function automatic logic [15:0] rand_angle();
    case ($urandom_range(7))
      0: return 16'd0;
      1: return 16'($urandom_range(7)) << 13;
      2: return 16'(int'($urandom_range(8)) - 4);
      default: return 16'($urandom());
    endcase
  endfunction

  initial begin
    point_t       p;
    longint       hi;
    longint       lo;
    int           n_items;
    hi = 2147483647;
    lo = -2147483648;
    n_items = 850;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: pass-through, half and quarter turns, one-step angles, clipping
    send_point(make_point(hi, lo, 65536, 0, 0, 0));
    send_point(make_point(lo, hi, -1, 0, 0, 0));
    send_point(make_point(65536, 131072, -196608, -32768, 0, 0));
    send_point(make_point(65536, 131072, -196608, 0, -32768, 0));
    send_point(make_point(65536, 131072, -196608, 0, 0, -32768));
    send_point(make_point(lo, lo, lo, -32768, -32768, -32768));
    send_point(make_point(hi, hi, hi, 16384, 16384, 16384));
    send_point(make_point(hi, hi, hi, -16384, -16384, -16384));
    send_point(make_point(hi, hi, hi, 8192, 8192, 8192));
    send_point(make_point(lo, lo, lo, 8192, -8192, 8192));
    send_point(make_point(hi, lo, hi, 32767, 32767, 32767));
    send_point(make_point(1000000, -1000000, 7, 1, 1, 1));
    send_point(make_point(1000000, -1000000, 7, -1, -1, -1));
    send_point(make_point(0, 0, 0, 12345, -23456, 30000));
    send_point(make_point(-1, 1, -1, 24576, -24576, 8191));
    send_point(make_point(hi, 0, 0, 0, 8192, 0));
    send_point(make_point(0, lo, 0, 8192, 0, 0));
    send_point(make_point(0, 0, hi, 0, 0, -8192));

    // Random points, moving through the idling patterns
    for (int i = 0; i < n_items; i++) begin
      if (i == n_items / 3) begin
        send_idle_pct = 52;
        recv_idle_pct = 32;
      end else if (i == (2 * n_items) / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      p.x = rand_coord();
      p.y = rand_coord();
      p.z = rand_coord();
      p.ax = rand_angle();
      p.ay = rand_angle();
      p.az = rand_angle();
      send_point(p);
    end
    in_chan.valid <= 1'b0;

    // Drain, then allow the pipe latency to pass
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    $display("rotated %0d points, %0d of them clipped, through three stall patterns",
             sb.checked, sb.sat_seen);
    $display("mismatch count %0d after %0d cycles", sb.mismatches, cycles);
    if (sb.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
